// ===== rtl/three_axis_moving_average_top_assert.svh =====
// ----------------------------------------------------------------------------
// three_axis_moving_average_top_assert
// assertion macros of the moving average rtl, sampled on the
// rising clock edge and disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_MOVING_AVERAGE_TOP_ASSERT_SVH
`define THREE_AXIS_MOVING_AVERAGE_TOP_ASSERT_SVH

// condition holds at every sampled edge
`define TMAV_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("tmav check failed");

// consequent holds in the same cycle as the antecedent
`define TMAV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tmav check failed");

// consequent holds in the cycle after the antecedent
`define TMAV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tmav check failed");

`endif

// ===== rtl/tmav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmav_pkg
// shared constants and types of the three-axis moving average
// ----------------------------------------------------------------------------
package tmav_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int AXIS_W  = 16;
    localparam int AXES    = 3;
    localparam int IN_W    = 6 * BYTE_W;
    localparam int OUT_W   = AXES * AXIS_W;
    localparam int SAMP_W  = AXES * AXIS_W;

    // default window length
    localparam int WINDOW_LEN_DEF = 10;

    // load enables for the divider stages
    typedef struct packed {
        logic ld_mul;
        logic ld_out;
    } t_stage_ctl;

endpackage

// ===== rtl/tmav_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmav_ram
// generic single-clock ram, one write port and one registered read port;
// a read at the address being written returns the old contents
// ----------------------------------------------------------------------------
module tmav_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 10,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tmav_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmav_div
// signed divide of a window sum by the window length, truncating toward
// zero; reciprocal multiply in the first stage, one-step correction and
// sign restore in the second
// ----------------------------------------------------------------------------
module tmav_div #(
    parameter int WINDOW_LEN = tmav_pkg::WINDOW_LEN_DEF,
    localparam int SUMW      = tmav_pkg::AXIS_W + $clog2(WINDOW_LEN),
    localparam int MAGW      = SUMW
) (
    input  logic                             i_clk,
    input  tmav_pkg::t_stage_ctl             i_ctl,
    input  logic signed [SUMW-1:0]           i_sum,
    output logic signed [tmav_pkg::AXIS_W-1:0] o_avg
);

    localparam logic [MAGW-1:0] RECIP = MAGW'((64'd1 << MAGW) / WINDOW_LEN);
    localparam logic [MAGW-1:0] DIV_C = MAGW'(WINDOW_LEN);

    logic [MAGW-1:0]   w_mag;
    logic [MAGW-1:0]   r_mag;
    logic              r_neg;
    logic [2*MAGW-1:0] r_prod;
    logic [MAGW-1:0]   w_q0;
    logic [MAGW-1:0]   w_qw;
    logic [MAGW-1:0]   w_rem;
    logic [MAGW-1:0]   w_q;
    logic [tmav_pkg::AXIS_W-1:0] n_avg;
    logic [tmav_pkg::AXIS_W-1:0] r_avg;

    // magnitude of the sum, full scale fits unsigned
    assign w_mag = i_sum[SUMW-1] ? MAGW'(-i_sum) : MAGW'(i_sum);

    // stage a: reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            r_mag  <= w_mag;
            r_neg  <= i_sum[SUMW-1];
            r_prod <= (2*MAGW)'(w_mag) * (2*MAGW)'(RECIP);
        end
    end

    // estimate is exact or one low, fix with the remainder
    assign w_q0  = r_prod[2*MAGW-1:MAGW];
    assign w_qw  = w_q0 * DIV_C;
    assign w_rem = r_mag - w_qw;
    assign w_q   = (w_rem >= DIV_C) ? (w_q0 + MAGW'(1)) : w_q0;
    assign n_avg = r_neg ? (-w_q[tmav_pkg::AXIS_W-1:0]) : w_q[tmav_pkg::AXIS_W-1:0];

    // stage b: result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            r_avg <= n_avg;
        end
    end

    assign o_avg = r_avg;

endmodule

// ===== rtl/three_axis_moving_average_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_moving_average_top
// ten-tap boxcar average of three magnetometer axes over a sample ring
// ----------------------------------------------------------------------------
// usage
//   slave channel: one transaction is one sample, six raw bytes in device
//   order x, z, y, high byte first. master channel: one transaction per
//   sample, the three window averages (sum / WINDOW_LEN, toward zero).
//   each sample passes the stage 1, sum, divider and output registers.
//   throughput: one sample per cycle while the receiver is ready, set by
//   the ring ram, read and written once per sample at the ring pointer.
//   the window samples sit in one ram, 3 x 16 bits per row; running sums
//   are kept in registers and updated from the row read out.
//   reset clears the ring pointer, the running sums and one valid flag per
//   ring row; rows not yet written read as zero, so no clearing pass runs.
//   when the receiver stalls, every stage holds its transaction and the
//   pipeline keeps accepting until its four slots are full, then
//   o_s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "three_axis_moving_average_top_assert.svh"

module three_axis_moving_average_top #(
    parameter int WINDOW_LEN = tmav_pkg::WINDOW_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // x_high, x_low, z_high, z_low, y_high, y_low
    input  logic [tmav_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // avg_x, avg_y, avg_z
    output logic [tmav_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam int AXIS_W = tmav_pkg::AXIS_W;
    localparam int AXES   = tmav_pkg::AXES;
    localparam int SAMP_W = tmav_pkg::SAMP_W;
    localparam int PTRW   = $clog2(WINDOW_LEN);
    localparam int SUMW   = AXIS_W + PTRW;
    localparam logic [PTRW-1:0] LAST_PTR = PTRW'(WINDOW_LEN - 1);

    // handshake and stage control
    logic w_accept;
    logic w_out_free, w_s3_free, w_s2_free, w_s1_free;
    logic w_ld2, w_ld3, w_ld_out;
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;
    tmav_pkg::t_stage_ctl w_ctl;

    // ring state
    logic [PTRW-1:0]       r_ptr;
    logic [WINDOW_LEN-1:0] r_row_vld;
    logic [SAMP_W-1:0]     w_sample;
    logic [SAMP_W-1:0]     w_rdata;
    logic [SAMP_W-1:0]     w_old;
    logic [SAMP_W-1:0]     r_s1_sample;
    logic                  r_s1_old_vld;

    // running sums
    logic signed [SUMW-1:0] r_sum    [AXES];
    logic signed [SUMW-1:0] n_sum    [AXES];
    logic signed [SUMW-1:0] r_s2_sum [AXES];
    logic signed [AXIS_W-1:0] w_avg  [AXES];

    // ready chain from the output register back to the input
    assign w_out_free      = !r_out_v || i_m_axis_tready;
    assign w_ld_out        = r_s3_v && w_out_free;
    assign w_s3_free       = !r_s3_v || w_out_free;
    assign w_ld3           = r_s2_v && w_s3_free;
    assign w_s2_free       = !r_s2_v || w_s3_free;
    assign w_ld2           = r_s1_v && w_s2_free;
    assign w_s1_free       = !r_s1_v || w_s2_free;
    assign o_s_axis_tready = w_s1_free;
    assign w_accept        = i_s_axis_tvalid && w_s1_free;

    assign w_ctl.ld_mul = w_ld3;
    assign w_ctl.ld_out = w_ld_out;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_v <= w_accept;
            end
            if (w_s2_free) begin
                r_s2_v <= w_ld2;
            end
            if (w_s3_free) begin
                r_s3_v <= w_ld3;
            end
            if (w_out_free) begin
                r_out_v <= w_ld_out;
            end
        end
    end

    // assemble the sample row: x low, y middle, z high
    assign w_sample = {i_s_axis_tdata[23:16], i_s_axis_tdata[31:24],
                       i_s_axis_tdata[39:32], i_s_axis_tdata[47:40],
                       i_s_axis_tdata[7:0],   i_s_axis_tdata[15:8]};

    // ring pointer and row valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_row_vld <= '0;
        end else if (w_accept) begin
            r_ptr            <= (r_ptr == LAST_PTR) ? '0 : (r_ptr + PTRW'(1));
            r_row_vld[r_ptr] <= 1'b1;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample  <= w_sample;
            r_s1_old_vld <= r_row_vld[r_ptr];
        end
    end

    // sample ring: old row read and new row written at the same pointer
    tmav_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_ptr),
        .i_wdata (w_sample),
        .i_re    (w_accept),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    // a row never written counts as zero
    assign w_old = r_s1_old_vld ? w_rdata : '0;

    // running sum update: drop the oldest, add the newest
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a]
                     - SUMW'(signed'(w_old[a*AXIS_W +: AXIS_W]))
                     + SUMW'(signed'(r_s1_sample[a*AXIS_W +: AXIS_W]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else if (w_ld2) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= n_sum[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            for (int a = 0; a < AXES; a++) begin
                r_s2_sum[a] <= n_sum[a];
            end
        end
    end

    // one divider per axis
    for (genvar g = 0; g < AXES; g++) begin : g_div
        tmav_div #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_div (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_sum (r_s2_sum[g]),
            .o_avg (w_avg[g])
        );
    end

    // result transaction: avg_x, avg_y, avg_z
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {w_avg[2], w_avg[1], w_avg[0]};

    // checks
    `TMAV_ASSERT_ALWAYS(a_ptr_range, i_clk, i_rst_n, r_ptr <= LAST_PTR)
    `TMAV_ASSERT_NXT(a_accept_marks_row, i_clk, i_rst_n, w_accept,
        r_s1_v && r_row_vld[$past(r_ptr)])
    `TMAV_ASSERT_NXT(a_s1_holds, i_clk, i_rst_n, r_s1_v && !w_s2_free,
        r_s1_v && $stable(r_s1_sample) && $stable(w_rdata))
    `TMAV_ASSERT_IMP(a_full_blocks_input, i_clk, i_rst_n,
        r_s1_v && r_s2_v && r_s3_v && r_out_v && !i_m_axis_tready,
        !o_s_axis_tready)

endmodule
